FILE: rtl/core/tksi_pkg.sv
// ----------------------------------------------------------------------------
// tksi_pkg: shared types and constants for the top-K sorted insert table
// Entry, request and response layouts, cell control, controller states.
// ----------------------------------------------------------------------------
package tksi_pkg;

   // build defaults
   localparam int ROWS_DEF = 256;
   localparam int K_DEF    = 16;

   // field widths
   localparam int ID_W       = 8;
   localparam int SCORE_W    = 32;
   localparam int ROW_W      = 8;
   localparam int RANK_W     = 4;
   localparam int POS_W      = 5;
   localparam int LIST_LEN_W = 5;

   localparam logic [LIST_LEN_W-1:0] LIST_LEN_RESET = 5'd16;
   localparam logic [POS_W-1:0]      NO_POSITION    = 5'd16;

   // operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   // one ranked entry
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SCORE_W-1:0] score;
   } tksi_entry_type;

   localparam int ENTRY_W = $bits(tksi_entry_type);

   // request beat
   typedef struct packed {
      logic              func;
      logic [ROW_W-1:0]  row;
      logic [ID_W-1:0]   cand_id;
      logic [SCORE_W-1:0] score;
      logic [RANK_W-1:0] rank;
   } tksi_req_type;

   // response beat
   typedef struct packed {
      logic               entered;
      logic [POS_W-1:0]   position;
      logic [ID_W-1:0]    read_id;
      logic [SCORE_W-1:0] read_score;
   } tksi_rsp_type;

   // controls common to every cell
   typedef struct packed {
      logic load;   // capture the row word this cycle
      logic ins;    // apply the insert while capturing
   } tksi_cell_ctl_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_WRITE
   } tksi_state_type;

endpackage

FILE: rtl/core/tksi_row_mem.sv
// ----------------------------------------------------------------------------
// tksi_row_mem: single write, single read row store
// One full row of ranked entries per word, registered read data.
// ----------------------------------------------------------------------------
module tksi_row_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 640
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/tksi_cell.sv
// ----------------------------------------------------------------------------
// tksi_cell: one rank of the insertion row
// Compares its entry with the candidate, passes the "all behind are lower"
// chain forward, and takes the candidate, its neighbor's entry, or its own.
// ----------------------------------------------------------------------------
module tksi_cell (
   input  logic                        clock,
   input  tksi_pkg::tksi_cell_ctl_type ctl,
   input  logic                        in_list,
   input  tksi_pkg::tksi_entry_type    own_in,
   input  tksi_pkg::tksi_entry_type    prev_in,
   input  tksi_pkg::tksi_entry_type    cand_in,
   input  logic                        tail_in,
   input  logic                        region_prev_in,
   output logic                        tail_out,
   output logic                        region_out,
   output logic                        land_out,
   output tksi_pkg::tksi_entry_type    entry_out
);

   tksi_pkg::tksi_entry_type entry_ff;
   tksi_pkg::tksi_entry_type entry_in;
   logic                     lt;

   // strictly lower than the candidate; ranks past the list pass the chain
   assign lt         = own_in.score < cand_in.score;
   assign tail_out   = in_list ? (lt & tail_in) : 1'b1;
   assign region_out = in_list & tail_out;
   assign land_out   = region_out & ~region_prev_in;

   // new value: candidate at the landing rank, shifted neighbor behind it
   always_comb begin
      entry_in = own_in;
      if (ctl.ins && region_out) begin
         entry_in = land_out ? cand_in : prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

FILE: rtl/core/tksi_cell_row.sv
// ----------------------------------------------------------------------------
// tksi_cell_row: chain of K insertion cells
// Wires the compare chain tail to head and the landing chain head to tail.
// ----------------------------------------------------------------------------
module tksi_cell_row #(
   parameter int K = 16
) (
   input  logic                                 clock,
   input  tksi_pkg::tksi_cell_ctl_type          ctl,
   input  logic [tksi_pkg::LIST_LEN_W-1:0]      len_eff,
   input  tksi_pkg::tksi_entry_type             cand,
   input  tksi_pkg::tksi_entry_type [K-1:0]     row_in,
   output tksi_pkg::tksi_entry_type [K-1:0]     row_out,
   output logic [K-1:0]                         land
);

   logic [K:0] tail;
   logic [K:0] region;

   // chain ends: nothing behind the last cell, nothing in front of the first
   assign tail[K]   = 1'b1;
   assign region[0] = 1'b0;

   for (genvar i = 0; i < K; i++) begin : g_cell
      tksi_pkg::tksi_entry_type prev;
      logic                     in_list;

      if (i == 0) begin : g_head
         assign prev = cand;
      end else begin : g_body
         assign prev = row_in[i-1];
      end

      assign in_list = 32'(i) < 32'(len_eff);

      tksi_cell u_cell (
         .clock          (clock),
         .ctl            (ctl),
         .in_list        (in_list),
         .own_in         (row_in[i]),
         .prev_in        (prev),
         .cand_in        (cand),
         .tail_in        (tail[i+1]),
         .region_prev_in (region[i]),
         .tail_out       (tail[i]),
         .region_out     (region[i+1]),
         .land_out       (land[i]),
         .entry_out      (row_out[i])
      );
   end

endmodule

FILE: rtl/core/top_k_sorted_insert_table.sv
// ----------------------------------------------------------------------------
// top_k_sorted_insert_table: per-row descending top-K list with insert/read
// A row word is read into a chain of K cells, updated in one pass and
// written back; reads pick one rank from the loaded row.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   req_data                   start & ~busy takes the beat
//  response  rsp_data                   rsp_strobe, one cycle, no stall
//  config    csr_wr_data                csr_wr_en writes list_length
//
//  Each item runs row memory read, cell update and write back; the next beat
//  is taken only once busy falls again. The response strobe is registered
//  from the write back state. After reset a clearing pass writes ROWS rows
//  (256 by default), one per cycle, with busy high; config writes still land.
//  The receiver cannot stall; busy is the only back-pressure.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_table #(
   parameter int ROWS = tksi_pkg::ROWS_DEF,
   parameter int K    = tksi_pkg::K_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  tksi_pkg::tksi_req_type             req_data,
   output logic                               rsp_strobe,
   output tksi_pkg::tksi_rsp_type             rsp_data,
   input  logic                               csr_wr_en,
   input  logic [tksi_pkg::LIST_LEN_W-1:0]    csr_wr_data
);

   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int DW     = K * tksi_pkg::ENTRY_W;

   tksi_pkg::tksi_state_type             state_ff, state_in;
   tksi_pkg::tksi_req_type               req_ff;
   logic [tksi_pkg::LIST_LEN_W-1:0]      list_length_ff;
   logic [tksi_pkg::LIST_LEN_W-1:0]      len_eff;
   logic [ROW_AW-1:0]                    clr_ff;
   logic                                 entered_ff;
   logic [tksi_pkg::POS_W-1:0]           pos_ff;
   logic [tksi_pkg::POS_W-1:0]           pos_in;
   logic                                 rsp_strobe_ff;
   tksi_pkg::tksi_rsp_type               rsp_ff, rsp_in;

   logic                                 accept;
   logic                                 row_ok;
   logic                                 do_ins;
   logic                                 mem_wr_en;
   logic [ROW_AW-1:0]                    mem_wr_addr;
   logic [DW-1:0]                        mem_wr_data;
   logic [DW-1:0]                        mem_rd_data;
   tksi_pkg::tksi_cell_ctl_type          cell_ctl;
   tksi_pkg::tksi_entry_type             cand;
   tksi_pkg::tksi_entry_type [K-1:0]     row_word;
   tksi_pkg::tksi_entry_type [K-1:0]     cells;
   tksi_pkg::tksi_entry_type             rd_sel;
   logic [K-1:0]                         land;

   assign accept = start & ~busy;
   assign row_ok = 32'(req_ff.row) < 32'(ROWS);
   assign do_ins = (req_ff.func == tksi_pkg::FUNC_INSERT) & row_ok;
   assign len_eff = (32'(list_length_ff) > 32'(K)) ?
                    tksi_pkg::LIST_LEN_W'(K) : list_length_ff;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         list_length_ff <= tksi_pkg::LIST_LEN_RESET;
      end else if (csr_wr_en) begin
         list_length_ff <= csr_wr_data;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // controller state and clear counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tksi_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tksi_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tksi_pkg::ST_CLEAR: begin
            if (clr_ff == ROW_AW'(ROWS - 1)) begin
               state_in = tksi_pkg::ST_IDLE;
            end
         end
         tksi_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tksi_pkg::ST_UPDATE;
            end
         end
         tksi_pkg::ST_UPDATE: begin
            state_in = tksi_pkg::ST_WRITE;
         end
         tksi_pkg::ST_WRITE: begin
            state_in = tksi_pkg::ST_IDLE;
         end
         default: begin
            state_in = tksi_pkg::ST_IDLE;
         end
      endcase
   end

   // controller outputs
   always_comb begin
      busy         = 1'b1;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ROW_AW'(req_ff.row);
      mem_wr_data  = cells;
      cell_ctl     = '0;
      unique case (state_ff)
         tksi_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
         end
         tksi_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         tksi_pkg::ST_UPDATE: begin
            cell_ctl.load = 1'b1;
            cell_ctl.ins  = do_ins;
         end
         tksi_pkg::ST_WRITE: begin
            mem_wr_en = do_ins;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   tksi_row_mem #(
      .DEPTH (ROWS),
      .AW    (ROW_AW),
      .DW    (DW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (ROW_AW'(req_data.row)),
      .rd_data (mem_rd_data)
   );

   assign row_word     = mem_rd_data;
   assign cand.id      = req_ff.cand_id;
   assign cand.score   = req_ff.score;

   tksi_cell_row #(
      .K (K)
   ) u_cells (
      .clock   (clock),
      .ctl     (cell_ctl),
      .len_eff (len_eff),
      .cand    (cand),
      .row_in  (row_word),
      .row_out (cells),
      .land    (land)
   );

   // landing rank, at most one cell lands
   always_comb begin
      pos_in = tksi_pkg::NO_POSITION;
      for (int i = 0; i < K; i++) begin
         if (land[i]) begin
            pos_in = tksi_pkg::POS_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tksi_pkg::ST_UPDATE) begin
         entered_ff <= do_ins & (|land);
         pos_ff     <= do_ins ? pos_in : tksi_pkg::NO_POSITION;
      end
   end

   // rank select for reads
   always_comb begin
      rd_sel = '0;
      for (int i = 0; i < K; i++) begin
         if (32'(req_ff.rank) == 32'(i)) begin
            rd_sel = cells[i];
         end
      end
   end

   // response beat
   always_comb begin
      rsp_in = '0;
      rsp_in.position = tksi_pkg::NO_POSITION;
      if (req_ff.func == tksi_pkg::FUNC_INSERT) begin
         rsp_in.entered  = entered_ff;
         rsp_in.position = pos_ff;
      end else if (row_ok) begin
         rsp_in.read_id    = rd_sel.id;
         rsp_in.read_score = rd_sel.score;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= state_ff == tksi_pkg::ST_WRITE;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tksi_pkg::ST_WRITE) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: rtl/core/tksi_checker.sv
// ----------------------------------------------------------------------------
// tksi_checker: port-level checks for the top-K sorted insert table
// Watches the request and response beats over time.
// ----------------------------------------------------------------------------
module tksi_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input tksi_pkg::tksi_rsp_type rsp_data
);

   // the clearing pass holds off requests right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   // a taken beat keeps the block busy
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after request beat");

   // every taken beat is answered by a response strobe
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("response beat missing");

   // a response is marked entered exactly when it carries a real rank
   a_pos_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.entered == (rsp_data.position != tksi_pkg::NO_POSITION)))
      else $error("entered and position disagree");

endmodule

bind top_k_sorted_insert_table tksi_checker u_tksi_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

FILE: tb/top_k_sorted_insert_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert_table_tb: self-checking bench for the top-K table
// Drives insert and read beats from a pending queue. It predicts every
// response from its own copy of the per-row sorted lists and the
// list_length register, and checks each response field by field.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_table_tb;

   localparam int IDLE_LIMIT = 2000;
   localparam int NUM_PHASES = 8;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            start       = 1'b0;
   logic                            busy;
   tksi_pkg::tksi_req_type          req_data    = '0;
   logic                            rsp_strobe;
   tksi_pkg::tksi_rsp_type          rsp_data;
   logic                            csr_wr_en   = 1'b0;
   logic [tksi_pkg::LIST_LEN_W-1:0] csr_wr_data = '0;

   // shadow of the table and the length register
   logic [tksi_pkg::SCORE_W-1:0]    score_tab [0:tksi_pkg::ROWS_DEF-1][0:tksi_pkg::K_DEF-1];
   logic [tksi_pkg::ID_W-1:0]       id_tab    [0:tksi_pkg::ROWS_DEF-1][0:tksi_pkg::K_DEF-1];
   logic [tksi_pkg::LIST_LEN_W-1:0] ranks_kept;

   tksi_pkg::tksi_req_type pending_reqs [$];
   tksi_pkg::tksi_rsp_type expected_rsps [$];

   bit req_taken;
   bit quiet;
   int gap_left;
   int idle_cycles;
   int errors;

   top_k_sorted_insert_table u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // insert into or read from the shadow lists, returning the response
   function automatic tksi_pkg::tksi_rsp_type predict_topk(input tksi_pkg::tksi_req_type r);
      tksi_pkg::tksi_rsp_type o;
      int len;
      int p;
      int i;
      o = '0;
      o.position = tksi_pkg::NO_POSITION;
      if (r.func == tksi_pkg::FUNC_INSERT) begin
         len = (ranks_kept > tksi_pkg::K_DEF) ? tksi_pkg::K_DEF : int'(ranks_kept);
         p = len;
         // walk up past every strictly lower score; ties stay in front
         while (p > 0 && score_tab[r.row][p-1] < r.score)
            p--;
         if (p < len) begin
            for (i = len - 1; i > p; i--) begin
               score_tab[r.row][i] = score_tab[r.row][i-1];
               id_tab[r.row][i]    = id_tab[r.row][i-1];
            end
            score_tab[r.row][p] = r.score;
            id_tab[r.row][p]    = r.cand_id;
            o.entered  = 1'b1;
            o.position = p[tksi_pkg::POS_W-1:0];
         end
      end else begin
         o.read_id    = id_tab[r.row][r.rank];
         o.read_score = score_tab[r.row][r.rank];
      end
      return o;
   endfunction

   function automatic tksi_pkg::tksi_req_type make_req(input logic f, input int row,
                                                       input int id,
                                                       input logic [31:0] score,
                                                       input int rank);
      tksi_pkg::tksi_req_type r;
      r.func    = f;
      r.row     = row[tksi_pkg::ROW_W-1:0];
      r.cand_id = id[tksi_pkg::ID_W-1:0];
      r.score   = score;
      r.rank    = rank[tksi_pkg::RANK_W-1:0];
      return r;
   endfunction

   // append one beat to the driver's pending list
   function automatic void queue_req(input tksi_pkg::tksi_req_type r);
      pending_reqs = {pending_reqs, r};
   endfunction

   // random beat: mostly a few busy rows, scores biased toward ties and extremes
   function automatic tksi_pkg::tksi_req_type rand_req();
      tksi_pkg::tksi_req_type r;
      logic [31:0]            s;
      int                     row;
      case ($urandom_range(0, 9))
         0:       s = '0;
         1:       s = '1;
         2, 3:    s = $urandom_range(0, 7);
         4:       s = $urandom_range(1, 7) << 12;
         default: s = $urandom();
      endcase
      case ($urandom_range(0, 4))
         0:       row = $urandom_range(0, 255);
         1:       row = $urandom_range(252, 255);
         default: row = $urandom_range(0, 3);
      endcase
      r = make_req(($urandom_range(0, 9) < 3) ? tksi_pkg::FUNC_READ : tksi_pkg::FUNC_INSERT,
                   row, $urandom_range(0, 255), s, $urandom_range(0, 15));
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // driver: new beat or idle at the falling edge, hold while not taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(1, 7) - 1;
               start <= 1'b0;
            end else begin
               req_data <= pending_reqs.pop_front();
               start    <= 1'b1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check responses, predict taken beats, track config, watchdog
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (reset) begin
         for (int r = 0; r < tksi_pkg::ROWS_DEF; r++)
            for (int k = 0; k < tksi_pkg::K_DEF; k++) begin
               score_tab[r][k] = '0;
               id_tab[r][k]    = '0;
            end
         ranks_kept = tksi_pkg::LIST_LEN_RESET;
         idle_cycles++;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response beat with none expected, actual %h", $time, rsp_data);
               errors++;
            end else begin
               tksi_pkg::tksi_rsp_type want;
               want = expected_rsps.pop_front();
               check_field("entered", want.entered, rsp_data.entered);
               check_field("position", want.position, rsp_data.position);
               check_field("read_id", want.read_id, rsp_data.read_id);
               check_field("read_score", want.read_score, rsp_data.read_score);
            end
         end
         if (start && !busy) begin
            req_taken = 1'b1;
            expected_rsps = {expected_rsps, predict_topk(req_data)};
         end
         if (csr_wr_en)
            ranks_kept = csr_wr_data;
         if (rsp_strobe || req_taken)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // wait until every beat is taken and every response has come back
   task automatic drain();
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [tksi_pkg::LIST_LEN_W-1:0] phase_len [NUM_PHASES];
      int                              n_items;
      phase_len = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd20, 5'd9, 5'd16};
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: empty reads, zero score, extremes, ties, same-row bursts
      queue_req(make_req(tksi_pkg::FUNC_READ,   0,    0, 32'h0, 0));
      queue_req(make_req(tksi_pkg::FUNC_INSERT, 0,    9, 32'h0, 0));
      queue_req(make_req(tksi_pkg::FUNC_INSERT, 0, 8'hFF, 32'hFFFF_FFFF, 0));
      queue_req(make_req(tksi_pkg::FUNC_INSERT, 0,    1, 32'h1, 0));
      queue_req(make_req(tksi_pkg::FUNC_INSERT, 0,    2, 32'h1, 0));
      queue_req(make_req(tksi_pkg::FUNC_INSERT, 0,    3, 32'h8000_0000, 0));
      queue_req(make_req(tksi_pkg::FUNC_INSERT, 0,    4, 32'hFFFF_FFFF, 0));
      queue_req(make_req(tksi_pkg::FUNC_INSERT, 255, 8'hAA, 32'h0000_1000, 15));
      for (int i = 0; i < 5; i++)
         queue_req(make_req(tksi_pkg::FUNC_READ, 0, 0, 32'h0, i));
      queue_req(make_req(tksi_pkg::FUNC_READ, 255, 0, 32'h0, 0));
      queue_req(make_req(tksi_pkg::FUNC_READ, 255, 0, 32'h0, 15));
      for (int i = 0; i < 6; i++)
         queue_req(make_req(tksi_pkg::FUNC_INSERT, 5, 16 + i, 32'h100 * (i + 1), 0));
      queue_req(make_req(tksi_pkg::FUNC_READ, 5, 0, 32'h0, 0));
      queue_req(make_req(tksi_pkg::FUNC_READ, 5, 0, 32'h0, 5));
      queue_req(make_req(tksi_pkg::FUNC_READ, 5, 0, 32'h0, 15));

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            drain();
            @(negedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= phase_len[ph];
            @(negedge clock);
            csr_wr_en   <= 1'b0;
         end
         // last stretch runs without driver gaps
         if (ph == NUM_PHASES - 1)
            quiet = 1'b1;
         n_items = (ph == NUM_PHASES - 1) ? 110 : 88;
         for (int i = 0; i < n_items; i++)
            queue_req(rand_req());
      end

      drain();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: top_k_sorted_insert_table.f
rtl/core/tksi_pkg.sv
rtl/core/tksi_row_mem.sv
rtl/core/tksi_cell.sv
rtl/core/tksi_cell_row.sv
rtl/core/top_k_sorted_insert_table.sv
rtl/core/tksi_checker.sv
tb/top_k_sorted_insert_table_tb.sv
